### rtl/utt_pkg.sv
package utt_pkg;

    localparam int unsigned UNIT_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HIGH_W = 10;
    localparam int unsigned MAX_BYTES = 4;
    localparam int unsigned CNT_W = 3;

    localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [UNIT_W-1:0] SURR_END       = 16'hE000;
    localparam logic [UNIT_W-1:0] ONE_BYTE_END   = 16'h0080;
    localparam logic [UNIT_W-1:0] TWO_BYTE_END   = 16'h0800;
    localparam logic [UNIT_W-1:0] CAP_DEFAULT    = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MARK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MARK = 8'hF0;
    localparam logic [BYTE_W-1:0] TERM_BYTE  = 8'h00;

    localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [CNT_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [CNT_W-1:0] LEN_FOUR = 3'd4;

    // decoder state carried between code units
    typedef struct packed {
        logic              high_pending;
        logic [HIGH_W-1:0] high_bits;
        logic [UNIT_W-1:0] room_left;
    } utt_state_t;

    // bytes of one character, first byte in slot 0
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic                             last;
    } utt_pack_t;

endpackage

### rtl/utt_if.sv
interface utt_unit_if
    import utt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink (input valid, input code_unit, output ready);
endinterface

interface utt_cfg_if
    import utt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink (input valid, input out_capacity, output ready);
endinterface

interface utt_byte_if
    import utt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

### rtl/utt_encoder.sv
module utt_encoder
    import utt_pkg::*;
(
    input  logic [UNIT_W-1:0] code_unit,
    input  logic [UNIT_W-1:0] out_capacity,
    input  utt_state_t        state,
    output utt_state_t        state_next,
    output utt_pack_t         pack
);

    logic              is_zero;
    logic              is_high;
    logic              is_low;
    logic              is_surr;
    logic              try_emit;
    logic              fits;
    logic [20:0]       cp;
    logic [4:0]        plane;
    logic [CNT_W-1:0]  len;

    always_comb
    begin
        is_zero = (code_unit == '0);
        is_high = code_unit inside {[SURR_HIGH_BASE:SURR_LOW_BASE-1]};
        is_low  = code_unit inside {[SURR_LOW_BASE:SURR_END-1]};
        is_surr = is_high | is_low;

        // pair adds 0x10000: only the plane field grows
        plane = {1'b0, state.high_bits[9:6]} + 5'd1;

        if (state.high_pending)
        begin
            cp       = {plane, state.high_bits[5:0], code_unit[9:0]};
            len      = LEN_FOUR;
            try_emit = is_low;
        end
        else
        begin
            cp       = {5'd0, code_unit};
            try_emit = !is_surr;
            if (code_unit < ONE_BYTE_END)
                len = LEN_ONE;
            else if (code_unit < TWO_BYTE_END)
                len = LEN_TWO;
            else
                len = LEN_THREE;
        end

        // one slot stays reserved for the terminator
        fits = (state.room_left > {{(UNIT_W-CNT_W){1'b0}}, len});

        state_next = state;
        pack.bytes = '0;
        pack.count = LEN_NONE;
        pack.last  = 1'b0;

        case (len)
            LEN_ONE:
            begin
                pack.bytes[0] = cp[7:0];
            end
            LEN_TWO:
            begin
                pack.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
                pack.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            end
            LEN_THREE:
            begin
                pack.bytes[0] = LEAD3_MARK | {4'b0000, cp[15:12]};
                pack.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
                pack.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            end
            default:
            begin
                pack.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
                pack.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
                pack.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
                pack.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            end
        endcase

        if (is_zero)
        begin
            state_next.high_pending = 1'b0;
            state_next.high_bits    = '0;
            state_next.room_left    = out_capacity;
            pack.bytes              = '0;
            pack.bytes[0]           = TERM_BYTE;
            pack.count              = LEN_ONE;
            pack.last               = 1'b1;
        end
        else
        begin
            state_next.high_pending = 1'b0;
            if (try_emit && fits)
            begin
                state_next.room_left = state.room_left - {{(UNIT_W-CNT_W){1'b0}}, len};
                pack.count           = len;
            end
            if (!state.high_pending && is_high)
            begin
                state_next.high_pending = 1'b1;
                state_next.high_bits    = code_unit[HIGH_W-1:0];
            end
        end
    end

endmodule

### rtl/utf16_to_utf8_transcoder.sv
// channel | dir | payload                | handshake
// --------+-----+------------------------+-----------
// units   | in  | code_unit[15:0]        | valid/ready
// utf8    | out | out_byte[7:0], last    | valid/ready
// cfg     | in  | out_capacity[15:0]     | valid/ready (ready always high)
//
// each code unit is decoded in the cycle it is accepted; its bytes land in a
// four-byte character buffer and leave through the output register, one word
// per cycle while utf8 is not stalled. the next unit is taken while the
// buffer's final byte moves out.
// reset clears the pending surrogate and sets capacity and room to 65535.
// a stall on utf8 holds the output word and, while the buffer holds bytes, units.
module utf16_to_utf8_transcoder
    import utt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    utt_unit_if.sink         units,
    utt_cfg_if.sink          cfg,
    utt_byte_if.source       utf8
);

    // decoder state and capacity register
    utt_state_t        state_reg;
    utt_state_t        state_next;
    utt_state_t        enc_state;
    logic [UNIT_W-1:0] cap_reg;
    logic [UNIT_W-1:0] cap_next;

    // character buffer
    utt_pack_t         enc_pack;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_reg;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              buf_last_reg;
    logic              buf_last_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              out_free;
    logic              move;
    logic              unit_ready;
    logic              unit_take;
    logic              cfg_take;

    utt_encoder u_encoder (
        .code_unit    (units.code_unit),
        .out_capacity (cap_reg),
        .state        (state_reg),
        .state_next   (enc_state),
        .pack         (enc_pack)
    );

    // output register can load when empty or being drained
    assign out_free   = !out_valid_reg || utf8.ready;
    assign move       = (cnt_reg != LEN_NONE) && out_free;
    // take a unit when the buffer is empty or its final byte leaves now
    assign unit_ready = (cnt_reg == LEN_NONE) || ((cnt_reg == LEN_ONE) && out_free);
    assign unit_take  = units.valid && unit_ready;
    assign cfg_take   = cfg.valid;

    assign units.ready   = unit_ready;
    assign cfg.ready     = 1'b1;
    assign utf8.valid    = out_valid_reg;
    assign utf8.out_byte = out_byte_reg;
    assign utf8.last     = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        cap_next   = cap_reg;
        if (unit_take)
            state_next = enc_state;
        // capacity write reloads the room, pending surrogate stays
        if (cfg_take)
        begin
            cap_next             = cfg.out_capacity;
            state_next.room_left = cfg.out_capacity;
        end
    end

    always_comb
    begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        buf_last_next = buf_last_reg;
        if (unit_take)
        begin
            buf_next      = enc_pack.bytes;
            cnt_next      = enc_pack.count;
            buf_last_next = enc_pack.last;
        end
        else if (move)
        begin
            // shift toward slot 0
            buf_next = {{BYTE_W{1'b0}}, buf_reg[MAX_BYTES-1:1]};
            cnt_next = cnt_reg - LEN_ONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = buf_reg[0];
            out_last_next  = buf_last_reg;
        end
        else if (utf8.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.high_pending <= 1'b0;
            state_reg.high_bits    <= '0;
            state_reg.room_left    <= CAP_DEFAULT;
            cap_reg                <= CAP_DEFAULT;
            cnt_reg                <= LEN_NONE;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        buf_last_reg <= buf_last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

### rtl/utt_checker.sv
module utt_checker
    import utt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              out_last
);

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output word changed under stall");

    // terminator word carries a zero byte
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_byte == TERM_BYTE)
        else $error("last set on a nonzero byte");

    // a zero byte only ever ends a string
    a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_byte == TERM_BYTE |-> out_last)
        else $error("zero byte without last");

    // nothing on the output right after reset
    a_reset_idle: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (utf8.valid),
    .out_ready (utf8.ready),
    .out_byte  (utf8.out_byte),
    .out_last  (utf8.last)
);
